// ===== rtl/mbps_pkg.sv =====
// Shared constants, register codes and helpers for the masked byte pattern scanner.
package mbps_pkg;

	// Sizes of the pattern window and the address path.
	localparam int MAX_PATTERN_BYTES = 16;
	localparam int HIST_DEPTH        = MAX_PATTERN_BYTES - 1;
	localparam int ADDRESS_BITS      = 48;
	localparam int WORD_BITS         = 64;
	localparam int LEN_BITS          = 5;
	localparam int PHASE_BITS        = 4;
	localparam int TAP_BITS          = 4;
	localparam int CFG_INDEX_BITS    = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_PATTERN_LOW  = 3'd0,
		CFG_PATTERN_HIGH = 3'd1,
		CFG_MASK_LOW     = 3'd2,
		CFG_MASK_HIGH    = 3'd3,
		CFG_PATTERN_LEN  = 3'd4,
		CFG_START_ALIGN  = 3'd5
	} cfg_reg_t;

	typedef logic [7:0]              byte_t;
	typedef logic [ADDRESS_BITS-1:0] addr_t;

	// Pattern length in use: values above the window size saturate, zero stays zero.
	function automatic logic [LEN_BITS-1:0] clamp_len(input logic [LEN_BITS-1:0] len);
		logic [LEN_BITS-1:0] r;
		r = len;
		if (len > LEN_BITS'(MAX_PATTERN_BYTES)) begin
			r = LEN_BITS'(MAX_PATTERN_BYTES);
		end
		return r;
	endfunction

	// Start alignment in use: zero acts as one, values above the phase reach saturate.
	function automatic logic [LEN_BITS-1:0] clamp_align(input logic [LEN_BITS-1:0] align);
		logic [LEN_BITS-1:0] r;
		r = align;
		if (align == '0) begin
			r = LEN_BITS'(1);
		end else if (align > LEN_BITS'(1 << PHASE_BITS)) begin
			r = LEN_BITS'(1 << PHASE_BITS);
		end
		return r;
	endfunction

endpackage

// ===== rtl/masked_byte_pattern_scan_top.sv =====
// Masked byte pattern scanner: sliding byte window, masked compare and result register.

// The scanner takes one byte beat per cycle, back to back while in_stall is low,
// and reports a match through a result register; the input stage keeps accepting
// while a result waits, so a stall on the result side only holds the input once
// both the input stage and the result register are full. A beat goes from the
// input register, where the masked compare of all sixteen window lanes runs in
// parallel, on to the result register. A window is the current byte plus up to
// fifteen earlier bytes of the same region; its start offset within the region
// must be a multiple of start_alignment. The window and the alignment phase clear
// after a beat flagged end_of_region, so no match spans two regions. Configuration
// writes take effect at once and should be made while no beat is in flight.
module masked_byte_pattern_scan_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [mbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [mbps_pkg::WORD_BITS-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          data_byte,
	input  logic [mbps_pkg::ADDRESS_BITS-1:0]   byte_address,
	input  logic                                end_of_region,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mbps_pkg::ADDRESS_BITS-1:0]   match_address,
	output logic [mbps_pkg::WORD_BITS-1:0]      matched_low,
	output logic [mbps_pkg::WORD_BITS-1:0]      matched_high
);
	import mbps_pkg::*;

	// Configuration registers.
	logic [WORD_BITS-1:0] pattern_low_q, pattern_high_q, mask_low_q, mask_high_q;
	logic [LEN_BITS-1:0]  pattern_len_q, start_align_q;

	// Input stage.
	logic        valid_s1;
	byte_t       data_s1;
	addr_t       addr_s1;
	logic        eor_s1;

	// Window history, newest entry at index 0.
	byte_t                 win_byte_q [HIST_DEPTH];
	addr_t                 win_addr_q [HIST_DEPTH];
	logic [HIST_DEPTH-1:0] win_ok_q;
	logic [PHASE_BITS-1:0] phase_q;

	// Result register.
	logic                 out_valid_q;
	addr_t                match_address_q;
	logic [WORD_BITS-1:0] matched_low_q, matched_high_q;

	// Handshake and compare signals.
	logic                        out_ready;
	logic                        adv_s1;
	logic                        load_s1;
	logic                        hit;
	logic [LEN_BITS-1:0]         len_eff;
	logic [LEN_BITS-1:0]         align_eff;
	logic [LEN_BITS-1:0]         phase_inc;
	logic [TAP_BITS-1:0]         start_tap;
	byte_t                       tap_byte [MAX_PATTERN_BYTES];
	addr_t                       tap_addr [MAX_PATTERN_BYTES];
	logic [MAX_PATTERN_BYTES-1:0] tap_ok;
	logic [2*WORD_BITS-1:0]      pattern_all, mask_all, matched_all;
	logic                        bytes_equal;
	addr_t                       start_addr;

	// The input register moves on whenever the result register is free or being emptied.
	assign out_ready = !out_valid_q || !out_stall;
	assign adv_s1    = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign load_s1   = in_valid && !in_stall;

	// Configuration write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			mask_low_q     <= '0;
			mask_high_q    <= '0;
			pattern_len_q  <= LEN_BITS'(1);
			start_align_q  <= LEN_BITS'(1);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_PATTERN_LOW:  pattern_low_q  <= cfg_data;
				CFG_PATTERN_HIGH: pattern_high_q <= cfg_data;
				CFG_MASK_LOW:     mask_low_q     <= cfg_data;
				CFG_MASK_HIGH:    mask_high_q    <= cfg_data;
				CFG_PATTERN_LEN:  pattern_len_q  <= cfg_data[LEN_BITS-1:0];
				CFG_START_ALIGN:  start_align_q  <= cfg_data[LEN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			data_s1 <= data_byte;
			addr_s1 <= byte_address;
			eor_s1  <= end_of_region;
		end
	end

	// Effective configuration and taps: tap 0 is the current byte, tap k is k bytes back.
	always_comb begin
		len_eff   = clamp_len(pattern_len_q);
		align_eff = clamp_align(start_align_q);
		tap_byte[0] = data_s1;
		tap_addr[0] = addr_s1;
		tap_ok[0]   = (phase_q == '0);
		for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
			tap_byte[k] = win_byte_q[k-1];
			tap_addr[k] = win_addr_q[k-1];
			tap_ok[k]   = win_ok_q[k-1];
		end
		start_tap  = TAP_BITS'(len_eff - LEN_BITS'(1));
		start_addr = tap_addr[start_tap];
	end

	// Masked compare over all lanes; lane i holds window byte i, oldest first.
	always_comb begin
		logic [LEN_BITS-1:0] sel;
		byte_t               b;
		pattern_all = {pattern_high_q, pattern_low_q};
		mask_all    = {mask_high_q, mask_low_q};
		matched_all = '0;
		bytes_equal = 1'b1;
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			sel = len_eff - LEN_BITS'(1) - LEN_BITS'(i);
			b   = tap_byte[sel[TAP_BITS-1:0]];
			if (LEN_BITS'(i) < len_eff) begin
				matched_all[i*8 +: 8] = b;
				if ((b & mask_all[i*8 +: 8]) != (pattern_all[i*8 +: 8] & mask_all[i*8 +: 8])) begin
					bytes_equal = 1'b0;
				end
			end
		end
		hit = (len_eff != '0) && tap_ok[start_tap] && bytes_equal;
	end

	// Next alignment phase, computed one bit wider so that sixteen wraps.
	assign phase_inc = {1'b0, phase_q} + LEN_BITS'(1);

	// Window control: shift in the current beat, or clear after the last byte of a region.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_ok_q <= '0;
			phase_q  <= '0;
		end else if (adv_s1) begin
			if (eor_s1) begin
				win_ok_q <= '0;
				phase_q  <= '0;
			end else begin
				win_ok_q <= {win_ok_q[HIST_DEPTH-2:0], tap_ok[0]};
				phase_q  <= (phase_inc >= align_eff) ? '0 : phase_inc[PHASE_BITS-1:0];
			end
		end
	end

	// Window payload shift.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			if (eor_s1) begin
				for (int k = 0; k < HIST_DEPTH; k++) begin
					win_byte_q[k] <= '0;
				end
			end else begin
				win_byte_q[0] <= data_s1;
				win_addr_q[0] <= addr_s1;
				for (int k = 1; k < HIST_DEPTH; k++) begin
					win_byte_q[k] <= win_byte_q[k-1];
					win_addr_q[k] <= win_addr_q[k-1];
				end
			end
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1 && hit;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv_s1 && hit) begin
			match_address_q <= start_addr;
			matched_low_q   <= matched_all[WORD_BITS-1:0];
			matched_high_q  <= matched_all[2*WORD_BITS-1:WORD_BITS];
		end
	end

	assign out_valid     = out_valid_q;
	assign match_address = match_address_q;
	assign matched_low   = matched_low_q;
	assign matched_high  = matched_high_q;

`ifndef SYNTHESIS
	// The input side only stalls while the input register holds a beat.
	a_stall_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	// After the last byte of a region leaves the input register, the window flags and the phase are clear.
	a_region_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && eor_s1) |=> (win_ok_q == '0 && phase_q == '0))
		else $error("window not cleared at end of region");

	// A new result only appears when a beat was in the input register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result beat without a source beat");
`endif

endmodule
